[sv/fla_pkg.sv]
// ----------------------------------------------------------------------------
// fla_pkg: shared types and microcode for the free list node allocator
// Command and status codes, port words, microcode format and program.
// ----------------------------------------------------------------------------
package fla_pkg;

  localparam int unsigned POOL_DEPTH_DEF = 1024;
  localparam int unsigned IDX_W          = 10;
  localparam int unsigned CAP_W          = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // comparisons run at a width that holds any pool depth
  localparam int unsigned WW = 17;
  localparam logic [WW-1:0] LINK_LIMIT_MAX = 17'd65535;
  localparam logic [WW-1:0] CAP_WIDE_LIMIT = 17'd65536;
  localparam logic [WW-1:0] COUNT_MAX_W    = 17'd1023;
  localparam logic [IDX_W-1:0] COUNT_MAX   = 10'd1023;

  typedef enum logic [1:0] {
    CMD_INIT     = 2'd0,
    CMD_SHUTDOWN = 2'd1,
    CMD_ALLOC    = 2'd2,
    CMD_FREE     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] node_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] alloc_index;
    status_e          status;
    logic [IDX_W-1:0] nodes_free;
    logic             initialized;
  } res_t;

  // ---- microcode ----
  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UP_IDLE        = 4'd0;
  localparam upc_t UP_INIT_TEST   = 4'd1;
  localparam upc_t UP_INIT_SETUP  = 4'd2;
  localparam upc_t UP_INIT_GUARD  = 4'd3;
  localparam upc_t UP_INIT_LINK   = 4'd4;
  localparam upc_t UP_DONE        = 4'd5;
  localparam upc_t UP_SHUT        = 4'd6;
  localparam upc_t UP_ALLOC_TEST  = 4'd7;
  localparam upc_t UP_ALLOC_POP   = 4'd8;
  localparam upc_t UP_ALLOC_EMPTY = 4'd9;
  localparam upc_t UP_FREE_TEST   = 4'd10;
  localparam upc_t UP_FREE_PUSH   = 4'd11;
  localparam upc_t UP_FREE_REJ    = 4'd12;

  typedef enum logic [2:0] {
    C_NEXT,       // fall through
    C_ALWAYS,
    C_DISPATCH,   // on start, jump to the entry of the command
    C_READY,
    C_LIM_SMALL,
    C_LINK_MORE,
    C_HEAD_BAD,
    C_IDX_BAD
  } cond_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT_SETUP,
    OP_INIT_LINK,
    OP_SHUTDOWN,
    OP_POP,
    OP_PUSH,
    OP_SET_EMPTY,
    OP_SET_REJECT
  } op_e;

  typedef struct packed {
    cond_e cond;
    upc_t  target;
    op_e   op;
    logic  strobe;
    logic  idle;
  } uword_t;

  // what the datapath sees of the current word
  typedef struct packed {
    op_e  op;
    logic strobe;
    logic idle;
  } ctl_t;

  // condition flags from the datapath
  typedef struct packed {
    logic ready;
    logic lim_small;
    logic link_more;
    logic head_bad;
    logic idx_bad;
  } flags_t;

  function automatic uword_t ucode(input upc_t pc);
    uword_t w;
    w = '{cond: C_ALWAYS, target: UP_IDLE, op: OP_NONE, strobe: 1'b0, idle: 1'b0};
    case (pc)
      UP_IDLE:        w = '{C_DISPATCH,  UP_IDLE,        OP_ACCEPT,     1'b0, 1'b1};
      UP_INIT_TEST:   w = '{C_READY,     UP_DONE,        OP_NONE,       1'b0, 1'b0};
      UP_INIT_SETUP:  w = '{C_NEXT,      UP_IDLE,        OP_INIT_SETUP, 1'b0, 1'b0};
      UP_INIT_GUARD:  w = '{C_LIM_SMALL, UP_DONE,        OP_NONE,       1'b0, 1'b0};
      UP_INIT_LINK:   w = '{C_LINK_MORE, UP_INIT_LINK,   OP_INIT_LINK,  1'b0, 1'b0};
      UP_DONE:        w = '{C_ALWAYS,    UP_IDLE,        OP_NONE,       1'b1, 1'b0};
      UP_SHUT:        w = '{C_ALWAYS,    UP_DONE,        OP_SHUTDOWN,   1'b0, 1'b0};
      UP_ALLOC_TEST:  w = '{C_HEAD_BAD,  UP_ALLOC_EMPTY, OP_NONE,       1'b0, 1'b0};
      UP_ALLOC_POP:   w = '{C_ALWAYS,    UP_DONE,        OP_POP,        1'b0, 1'b0};
      UP_ALLOC_EMPTY: w = '{C_ALWAYS,    UP_DONE,        OP_SET_EMPTY,  1'b0, 1'b0};
      UP_FREE_TEST:   w = '{C_IDX_BAD,   UP_FREE_REJ,    OP_NONE,       1'b0, 1'b0};
      UP_FREE_PUSH:   w = '{C_ALWAYS,    UP_DONE,        OP_PUSH,       1'b0, 1'b0};
      UP_FREE_REJ:    w = '{C_ALWAYS,    UP_DONE,        OP_SET_REJECT, 1'b0, 1'b0};
      default:        w = '{C_ALWAYS,    UP_IDLE,        OP_NONE,       1'b0, 1'b0};
    endcase
    return w;
  endfunction

  function automatic upc_t entry(input cmd_e cmd);
    upc_t e;
    case (cmd)
      CMD_INIT:     e = UP_INIT_TEST;
      CMD_SHUTDOWN: e = UP_SHUT;
      CMD_ALLOC:    e = UP_ALLOC_TEST;
      CMD_FREE:     e = UP_FREE_TEST;
      default:      e = UP_IDLE;
    endcase
    return e;
  endfunction

  // link limit of a pool of the given capacity
  function automatic logic [WW-1:0] link_limit(input logic [WW-1:0] cap);
    return (cap < CAP_WIDE_LIMIT) ? cap : LINK_LIMIT_MAX;
  endfunction

endpackage

[sv/fla_useq.sv]
// ----------------------------------------------------------------------------
// fla_useq: microcode sequencer
// Step counter, control store and conditional jump logic.
// ----------------------------------------------------------------------------
module fla_useq import fla_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  input  cmd_e   cmd_i,
  input  flags_t flags_i,
  output ctl_t   ctl_o
);

  upc_t   pc_q, pc_d;
  uword_t w;
  logic   taken;

  assign w = ucode(pc_q);
  assign ctl_o = '{op: w.op, strobe: w.strobe, idle: w.idle};

  always_comb begin
    taken = 1'b0;
    case (w.cond)
      C_NEXT:      taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_DISPATCH:  taken = 1'b1;
      C_READY:     taken = flags_i.ready;
      C_LIM_SMALL: taken = flags_i.lim_small;
      C_LINK_MORE: taken = flags_i.link_more;
      C_HEAD_BAD:  taken = flags_i.head_bad;
      C_IDX_BAD:   taken = flags_i.idx_bad;
      default:     taken = 1'b1;
    endcase
  end

  always_comb begin
    if (w.cond == C_DISPATCH) begin
      pc_d = start ? entry(cmd_i) : pc_q;
    end else if (taken) begin
      pc_d = w.target;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[sv/free_list_node_allocator.sv]
// ----------------------------------------------------------------------------
// free_list_node_allocator: fixed-size node pool on a LIFO free list
// Microcoded sequencer over a head register, free counter and link memory.
// ----------------------------------------------------------------------------
// One command word is taken when start is high and busy is low. Its result
// word appears for exactly one cycle with done_o high and must be taken
// then: nothing holds it. Steps per word, each ending in result and idle:
// alloc and free test, then pop or push; shutdown shuts; init on a ready
// pool tests; below a link limit of two it tests, sets up and guards; a
// real init also links each slot of the capacity clipped to POOL_DEPTH,
// one slot per cycle on the link memory's single write port. The head's
// link is read into a register every cycle, so the pop finds it with no
// extra wait. Capacity is sampled at init only; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module free_list_node_allocator import fla_pkg::*; #(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output res_t             res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(POOL_DEPTH);
  localparam int unsigned CPW = $clog2(POOL_DEPTH + 1);
  localparam logic [WW-1:0] DEPTH_W = WW'(POOL_DEPTH);

  ctl_t   ctl;
  flags_t flags;

  // control state
  logic [CAP_W-1:0] capacity_q;
  logic [AW-1:0]    head_q, head_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic             ready_q, ready_d;
  logic [CPW-1:0]   cap_q, cap_d;

  // payload
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [AW-1:0]    got_q, got_d;
  status_e          status_q, status_d;
  logic [AW-1:0]    ctr_q, ctr_d;

  // link memory
  logic [AW-1:0] link_mem [POOL_DEPTH];
  logic [AW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] waddr, wdata;

  // wide views for compares
  logic [WW-1:0] cap_eff_w, lim_eff_w, lim_w, head_w, idx_w, ctr_next_w, got_w;
  logic [WW-1:0] cap_cfg_w, cap_w, count_init_w;

  fla_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .cmd_i   (req_i.cmd),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  assign busy        = !ctl.idle;
  assign cfg_ready_o = 1'b1;

  // effective capacity is the register clipped to the pool depth
  assign cap_cfg_w  = WW'(capacity_q);
  assign cap_eff_w  = (cap_cfg_w > DEPTH_W) ? DEPTH_W : cap_cfg_w;
  assign lim_eff_w  = link_limit(cap_eff_w);
  assign count_init_w = ((lim_eff_w - 17'd1) > COUNT_MAX_W) ? COUNT_MAX_W
                                                            : (lim_eff_w - 17'd1);

  assign cap_w      = WW'(cap_q);
  assign lim_w      = link_limit(cap_w);
  assign head_w     = WW'(head_q);
  assign idx_w      = WW'(idx_q);
  assign got_w      = WW'(got_q);
  assign ctr_next_w = WW'(ctr_q) + 17'd1;

  assign flags.ready     = ready_q;
  assign flags.lim_small = lim_w < 17'd2;
  assign flags.link_more = ctr_next_w < lim_w;
  assign flags.head_bad  = (head_w == '0) || (head_w >= cap_w) || (head_w >= DEPTH_W);
  assign flags.idx_bad   = !ready_q || (idx_w == '0) || (idx_w >= cap_w) ||
                           (idx_w >= DEPTH_W);

  // datapath, one operation per control word
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    ready_d  = ready_q;
    cap_d    = cap_q;
    idx_d    = idx_q;
    got_d    = got_q;
    status_d = status_q;
    ctr_d    = ctr_q;
    we       = 1'b0;
    waddr    = ctr_q;
    wdata    = head_q;
    case (ctl.op)
      OP_ACCEPT: begin
        if (start) begin
          idx_d    = req_i.node_index;
          got_d    = '0;
          status_d = ST_OK;
        end
      end
      OP_INIT_SETUP: begin
        ready_d = 1'b1;
        cap_d   = cap_eff_w[CPW-1:0];
        ctr_d   = AW'(1);
        if (lim_eff_w < 17'd2) begin
          head_d  = '0;
          count_d = '0;
        end else begin
          head_d  = AW'(1);
          count_d = count_init_w[IDX_W-1:0];
        end
      end
      OP_INIT_LINK: begin
        // slot ctr links to ctr+1, the last slot ends the list
        we    = 1'b1;
        waddr = ctr_q;
        wdata = flags.link_more ? ctr_next_w[AW-1:0] : '0;
        ctr_d = ctr_next_w[AW-1:0];
      end
      OP_SHUTDOWN: begin
        ready_d = 1'b0;
        cap_d   = '0;
        head_d  = '0;
        count_d = '0;
      end
      OP_POP: begin
        got_d  = head_q;
        head_d = rd_q;
        if (count_q != '0) count_d = count_q - 10'd1;
      end
      OP_PUSH: begin
        we     = 1'b1;
        waddr  = idx_w[AW-1:0];
        wdata  = head_q;
        head_d = idx_w[AW-1:0];
        if (count_q != COUNT_MAX) count_d = count_q + 10'd1;
      end
      OP_SET_EMPTY:  status_d = ST_EMPTY;
      OP_SET_REJECT: status_d = ST_REJECT;
      OP_NONE:       ;
      default:       ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
      head_q     <= '0;
      count_q    <= '0;
      ready_q    <= 1'b0;
      cap_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) capacity_q <= cfg_data_i;
      head_q  <= head_d;
      count_q <= count_d;
      ready_q <= ready_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    got_q    <= got_d;
    status_q <= status_d;
    ctr_q    <= ctr_d;
  end

  // the link of the current head is always being read
  always_ff @(posedge clk_i) begin
    if (we) link_mem[waddr] <= wdata;
    rd_q <= link_mem[head_q];
  end

  assign done_o            = ctl.strobe;
  assign res_o.alloc_index = got_w[IDX_W-1:0];
  assign res_o.status      = status_q;
  assign res_o.nodes_free  = count_q;
  assign res_o.initialized = ready_q;

endmodule
